// ===== src/sset_pkg.sv =====
`timescale 1ns / 1ps

package sset_pkg;

  // default number of cells in the chain
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } fsm_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic capture;  // take compare flags against the incoming value
    logic ins;      // open a slot and place the value
    logic del;      // close the slot of the matching entry
  } cell_ctl_t;

endpackage

// ===== src/sset_cell.sv =====
`timescale 1ns / 1ps

module sset_cell (
  input  logic                                clk,
  input  sset_pkg::cell_ctl_t                 ctl,
  input  logic signed [sset_pkg::VALUE_W-1:0] cmp_value,
  input  logic signed [sset_pkg::VALUE_W-1:0] ins_value,
  input  logic                                valid,
  input  logic signed [sset_pkg::VALUE_W-1:0] left_entry,
  input  logic                                left_lt,
  input  logic signed [sset_pkg::VALUE_W-1:0] right_entry,
  output logic signed [sset_pkg::VALUE_W-1:0] entry,
  output logic                                lt,
  output logic                                eq
);

  // compare flags against the value of the word just taken
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt <= valid && (entry < cmp_value);
      eq <= valid && (entry == cmp_value);
    end
  end

  // smaller entries stay, the rest move one place up or down
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      entry <= left_lt ? ins_value : left_entry;
    end else if (ctl.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== src/sorted_set_insert_remove.sv =====
`timescale 1ns / 1ps

// Sorted set of distinct signed 32-bit values, kept in ascending order in a
// chain of DEPTH cells. Each input word is one operation: insert value,
// remove value, or read the entry at an index. Every word gives exactly one
// result word with a status, the count after the operation and the read data.
// Input channel: s_tuser carries the op code, s_tdata the value and index.
// Output channel: m_tdata carries status, count and read value.
// Timing: a word is taken in one cycle, in which every cell compares its
// entry with the value; then, in S_APPLY once the output register is free,
// the cells shift in parallel and the result is loaded into the output
// register. A new word is not taken until that shift is done, as the
// compare and the shift both use the cell chain.
// The next word is taken while an earlier result still waits on m_tready;
// its update is held back until the output register is free, so a stalled
// receiver stops the block after one waiting result.
// Reset (rst, synchronous) empties the set and drops any pending result;
// cell contents are not cleared since unused cells are never read.
module sorted_set_insert_remove #(
  parameter int DEPTH = sset_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] value, [35:32] index, upper bits zero
  input  logic [sset_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] op
  input  logic [sset_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] status, [7:3] count, [39:8] read_value
  output logic [sset_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int VW   = sset_pkg::VALUE_W;
  localparam int IW   = sset_pkg::INDEX_W;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = CW + IW;
  localparam int RD_N = (DEPTH < (1 << IW)) ? DEPTH : (1 << IW);

  sset_pkg::fsm_t      state, state_next;
  sset_pkg::cell_ctl_t ctl;
  sset_pkg::op_t       cur_op;
  sset_pkg::status_t   status;

  logic signed [VW-1:0] cur_value;
  logic [IW-1:0]        cur_index;
  logic [CW-1:0]        count, count_next;
  logic signed [VW-1:0] rd_value;

  logic signed [VW-1:0] ent [DEPTH];
  logic [DEPTH-1:0]     lt_vec;
  logic [DEPTH-1:0]     eq_vec;

  logic accept, out_free, apply, hit, ins_ok, del_ok;

  logic signed [VW-1:0] in_value;
  assign in_value = s_tdata[VW-1:0];

  // chain of cells
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [VW-1:0] left_ent, right_ent;
    logic                 left_flag;

    if (gi == 0) begin : g_first
      assign left_ent  = '0;
      assign left_flag = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[gi-1];
      assign left_flag = lt_vec[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_ent = ent[gi];
    end else begin : g_inner
      assign right_ent = ent[gi+1];
    end

    sset_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cmp_value   (in_value),
      .ins_value   (cur_value),
      .valid       (count > CW'(gi)),
      .left_entry  (left_ent),
      .left_lt     (left_flag),
      .right_entry (right_ent),
      .entry       (ent[gi]),
      .lt          (lt_vec[gi]),
      .eq          (eq_vec[gi])
    );
  end

  // handshake and cell control
  assign s_tready = (state == sset_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign apply    = (state == sset_pkg::S_APPLY) && out_free;
  assign hit      = |eq_vec;
  // capture, ins, del
  assign ctl      = {accept, apply && ins_ok, apply && del_ok};

  // operation decode, status and next count
  always_comb begin
    status     = sset_pkg::ST_OK;
    count_next = count;
    rd_value   = '0;
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    case (cur_op)
      sset_pkg::OP_INSERT: begin
        if (count == CW'(DEPTH)) begin
          status = sset_pkg::ST_FULL;
        end else if (hit) begin
          status = sset_pkg::ST_DUP;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      sset_pkg::OP_REMOVE: begin
        if (count == '0) begin
          status = sset_pkg::ST_EMPTY;
        end else if (!hit) begin
          status = sset_pkg::ST_NOT_FOUND;
        end else begin
          del_ok     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      sset_pkg::OP_READ: begin
        if (CMPW'(cur_index) >= CMPW'(count)) begin
          status = sset_pkg::ST_RANGE;
        end else begin
          for (int k = 0; k < RD_N; k++) begin
            if (cur_index == IW'(k)) begin
              rd_value = ent[k];
            end
          end
        end
      end
      default: begin
        status = sset_pkg::ST_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      sset_pkg::S_IDLE: begin
        if (accept) state_next = sset_pkg::S_APPLY;
      end
      sset_pkg::S_APPLY: begin
        if (apply) state_next = sset_pkg::S_IDLE;
      end
      default: state_next = sset_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sset_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operation register
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= sset_pkg::op_t'(s_tuser);
      cur_value <= in_value;
      cur_index <= s_tdata[VW+IW-1:VW];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      m_tdata <= {rd_value, sset_pkg::COUNT_W'(count_next), status};
    end
  end

endmodule
